### hw/rtl/vas_pkg.sv
package vas_pkg;

  localparam int FRAME_MAX = 1024;
  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam int SUM_W = 30 + CNT_W;
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QFW = $clog2(QDEPTH + 1);

  localparam logic [2:0] REG_START_THR = 3'd0;
  localparam logic [2:0] REG_END_THR   = 3'd1;
  localparam logic [2:0] REG_START_FR  = 3'd2;
  localparam logic [2:0] REG_SIL_LIM   = 3'd3;
  localparam logic [2:0] REG_MIN_UTT   = 3'd4;
  localparam logic [2:0] REG_MAX_UTT   = 3'd5;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_DISCARD = 2'd2;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [15:0]      peak;
    logic [CNT_W-1:0] n;
  } frame_t;

endpackage

### hw/rtl/vas_front.sv
module vas_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  sample,
  input  logic                frame_end,
  output logic                q_valid,
  input  logic                q_stall,
  output vas_pkg::frame_t     q_data
);

  logic [vas_pkg::SUM_W-1:0] sum;
  logic [15:0]               peak;
  logic [vas_pkg::CNT_W-1:0] cnt;
  vas_pkg::frame_t           mem [vas_pkg::QDEPTH];
  logic [vas_pkg::QAW-1:0]   wp, rp;
  logic [vas_pkg::QFW-1:0]   fill;
  logic [15:0]               mag;
  logic [31:0]               sq;
  logic [vas_pkg::SUM_W-1:0] sum_next;
  logic [15:0]               peak_next;
  logic [vas_pkg::CNT_W-1:0] cnt_next;
  logic                      acc, last, push, pop;

  assign mag = sample[15] ? 16'(-sample) : 16'(sample);
  assign sq = mag * mag;
  assign in_stall = (fill == vas_pkg::QFW'(vas_pkg::QDEPTH));
  assign acc = in_valid && !in_stall;
  assign sum_next = sum + vas_pkg::SUM_W'(sq);
  assign peak_next = (mag > peak) ? mag : peak;
  assign cnt_next = cnt + 1'b1;
  assign last = frame_end || (cnt_next == vas_pkg::CNT_W'(vas_pkg::FRAME_MAX));
  assign push = acc && last;
  assign q_valid = (fill != '0);
  assign pop = q_valid && !q_stall;
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      peak <= '0;
      cnt <= '0;
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (acc) begin
        if (last) begin
          sum <= '0;
          peak <= '0;
          cnt <= '0;
        end else begin
          sum <= sum_next;
          peak <= peak_next;
          cnt <= cnt_next;
        end
      end
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      fill <= fill + vas_pkg::QFW'(push) - vas_pkg::QFW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= '{sum: sum_next, peak: peak_next, n: cnt_next};
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= vas_pkg::QFW'(vas_pkg::QDEPTH)) else $error("queue overfill");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !push) else $error("push while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < vas_pkg::CNT_W'(vas_pkg::FRAME_MAX)) else $error("frame count overrun");
`endif

endmodule

### hw/rtl/vas_back.sv
module vas_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_stall,
  input  vas_pkg::frame_t    q_data,
  input  logic [15:0]        start_threshold,
  input  logic [15:0]        end_threshold,
  input  logic [7:0]         start_frames,
  input  logic [9:0]         silence_frames_limit,
  input  logic [19:0]        min_utterance,
  input  logic [19:0]        max_utterance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        rms_value,
  output logic [7:0]         wave_level,
  output logic [7:0]         meter_level,
  output logic               speech_on,
  output logic               frame_taken,
  output logic [1:0]         utterance_event,
  output logic               hit_length_cap,
  output logic [19:0]        utterance_length
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_LVL  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_MTR  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int SW = vas_pkg::SUM_W;
  localparam int DCW = $clog2(SW + 1);

  logic [2:0]               state;
  logic [SW-1:0]            quo;
  logic [vas_pkg::CNT_W:0]  rem;
  logic [vas_pkg::CNT_W-1:0] n;
  logic [15:0]              peak;
  logic [DCW-1:0]           step;
  logic [31:0]              sv;
  logic [16:0]              root;
  logic [33:0]              srem;
  logic [4:0]               sstep;
  logic [15:0]              rms;
  logic                     speech;
  logic [7:0]               vrun;
  logic [9:0]               srun;
  logic [19:0]              cap_len;
  logic [15:0]              lat;
  // meter divider: numerator up to 16 bits * 255, divisor up to 16 bits
  logic [23:0]              lnum;
  logic [23:0]              lquo;
  logic [16:0]              lrem;
  logic [15:0]              lden;
  logic [4:0]               lstep;
  logic [7:0]               plev, rlev;
  logic                     lsat0, lsat1;
  // constant divides by 2200 and 2160 done as reciprocal multiplies
  logic [19:0]              pnum, rnum;
  logic [39:0]              pprod, rprod;
  logic                     taken, cap_hit;
  logic [1:0]               ev;
  logic [19:0]              ulen;

  logic [vas_pkg::CNT_W:0]  rem_sh;
  logic [33:0]              trial;
  logic [16:0]              lrem_sh;
  logic [20:0]              len_sum;
  logic                     voiced;
  logic [15:0]              mlo, mhi;
  logic [7:0]               vrun_inc;
  logic [9:0]               srun_inc;
  logic                     out_fire;

  assign q_stall = (state != S_IDLE);
  assign rem_sh = {rem[vas_pkg::CNT_W-1:0], quo[SW-1]};
  assign trial = {srem[31:0], sv[31:30]} - {15'd0, root, 2'b01};
  assign lrem_sh = {lrem[15:0], lnum[23]};
  assign len_sum = {1'b0, cap_len} + 21'(n);
  assign voiced = rms >= (speech ? end_threshold : start_threshold);
  assign vrun_inc = (vrun == 8'hff) ? vrun : vrun + 8'd1;
  assign srun_inc = (srun == 10'h3ff) ? srun : srun + 10'd1;
  assign mlo = speech ? end_threshold : 16'd80;
  assign mhi = speech ? 16'd9000 : 16'd2200;
  assign pprod = {20'd0, pnum} * 40'd1952258;
  assign rprod = {20'd0, rnum} * 40'd1988411;
  assign out_fire = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      speech <= 1'b0;
      vrun <= '0;
      srun <= '0;
      cap_len <= '0;
      lat <= '0;
    end else begin
      if (out_fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            quo <= q_data.sum;
            rem <= '0;
            n <= q_data.n;
            peak <= q_data.peak;
            step <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (rem_sh >= {1'b0, n}) begin
            rem <= rem_sh - {1'b0, n};
            quo <= {quo[SW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[SW-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == DCW'(SW - 1)) begin
            state <= S_SQRT;
            sstep <= '0;
            root <= '0;
            srem <= '0;
          end
        end
        S_SQRT: begin
          // mean square fits in 32 bits; two bits a cycle
          if (sstep == 5'd0) begin
            sv <= quo[31:0];
            sstep <= 5'd1;
          end else begin
            if (!trial[33]) begin
              srem <= trial;
              root <= {root[15:0], 1'b1};
            end else begin
              srem <= {srem[31:0], sv[31:30]};
              root <= {root[15:0], 1'b0};
            end
            sv <= {sv[29:0], 2'b00};
            sstep <= sstep + 5'd1;
            if (sstep == 5'd16) begin
              state <= S_LVL;
              lstep <= '0;
            end
          end
        end
        S_LVL: begin
          rms <= root[15:0];
          if (lstep == 5'd0) begin
            pnum <= {4'd0, (peak > 16'd2200) ? 16'd2200 : peak} * 20'd255;
            rnum <= {4'd0, root[15:0] - 16'd40} * 20'd255;
            lstep <= 5'd1;
          end else begin
            plev <= pprod[39:32];
            rlev <= (rms <= 16'd40) ? 8'd0 :
                    ((rms >= 16'd2200) ? 8'd255 : rprod[39:32]);
            state <= S_DEC;
          end
        end
        S_DEC: begin
          lat <= rms;
          taken <= 1'b0;
          cap_hit <= 1'b0;
          ev <= vas_pkg::EV_NONE;
          ulen <= '0;
          if (!speech) begin
            if (voiced) begin
              vrun <= vrun_inc;
              if (vrun_inc >= start_frames) begin
                speech <= 1'b1;
                srun <= '0;
                cap_len <= '0;
              end
            end else begin
              vrun <= '0;
            end
          end else if (len_sum > {1'b0, max_utterance}) begin
            cap_hit <= 1'b1;
            ulen <= cap_len;
            ev <= (cap_len < min_utterance) ? vas_pkg::EV_DISCARD : vas_pkg::EV_ACCEPT;
            cap_len <= '0;
            speech <= 1'b0;
            srun <= '0;
            vrun <= '0;
            lat <= '0;
          end else begin
            taken <= 1'b1;
            cap_len <= len_sum[19:0];
            if (voiced) begin
              srun <= '0;
            end else begin
              srun <= srun_inc;
              if (srun_inc >= silence_frames_limit) begin
                ulen <= len_sum[19:0];
                ev <= (len_sum[19:0] < min_utterance) ?
                      vas_pkg::EV_DISCARD : vas_pkg::EV_ACCEPT;
                cap_len <= '0;
                speech <= 1'b0;
                srun <= '0;
                vrun <= '0;
                lat <= '0;
              end
            end
          end
          state <= S_MTR;
          lstep <= '0;
        end
        S_MTR: begin
          if (lstep == 5'd0) begin
            lsat0 <= (lat <= mlo);
            lsat1 <= (lat >= mhi);
            lnum <= {8'd0, lat - mlo} * 24'd255;
            lden <= mhi - mlo;
            lrem <= '0;
            lstep <= 5'd1;
          end else begin
            if (lrem_sh >= {1'b0, lden}) begin
              lrem <= lrem_sh - {1'b0, lden};
              lquo <= {lquo[22:0], 1'b1};
            end else begin
              lrem <= lrem_sh;
              lquo <= {lquo[22:0], 1'b0};
            end
            lnum <= {lnum[22:0], 1'b0};
            lstep <= lstep + 5'd1;
            if (lstep == 5'd24) state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            rms_value <= rms;
            wave_level <= (plev > rlev) ? plev : rlev;
            meter_level <= (lsat0 || lat == 16'd0) ? 8'd0 :
                           (lsat1 ? 8'd255 : lquo[7:0]);
            speech_on <= speech;
            frame_taken <= taken;
            hit_length_cap <= cap_hit;
            utterance_event <= ev;
            utterance_length <= ulen;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ev_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && utterance_event == vas_pkg::EV_NONE |-> utterance_length == 20'd0)
    else $error("length without event");
  a_take_ev: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_length_cap |-> !frame_taken && !speech_on)
    else $error("cap frame taken");
  a_take_speech: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_taken && utterance_event == vas_pkg::EV_NONE |-> speech_on)
    else $error("taken while idle");
`endif

endmodule

### hw/rtl/voice_activity_segmenter_core.sv
// channel  | handshake          | payload
// in       | in_valid/in_stall  | sample, frame_end
// out      | out_valid/out_stall| rms_value .. utterance_length
// cfg      | cfg_we             | cfg_index, cfg_data
// samples are taken one a cycle while in_stall is low; a frame summary is queued
// at each frame end or at the FRAME_MAX-th sample of a frame; the back end takes
// one summary at a time: divider, square root, level scaling, decision, meter
// divider, output; a result is offered when its summary is done, later if the
// previous result is still stalled; input stalls only while two summaries wait
// synchronous active-high reset restores registers to their defaults
module voice_activity_segmenter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        rms_value,
  output logic [7:0]         wave_level,
  output logic [7:0]         meter_level,
  output logic               speech_on,
  output logic               frame_taken,
  output logic [1:0]         utterance_event,
  output logic               hit_length_cap,
  output logic [19:0]        utterance_length,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  logic [15:0] start_threshold, end_threshold;
  logic [7:0]  start_frames;
  logic [9:0]  silence_frames_limit;
  logic [19:0] min_utterance, max_utterance;
  logic        q_valid, q_stall;
  vas_pkg::frame_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_threshold <= 16'd400;
      end_threshold <= 16'd200;
      start_frames <= 8'd3;
      silence_frames_limit <= 10'd25;
      min_utterance <= 20'd4800;
      max_utterance <= 20'd160000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vas_pkg::REG_START_THR: start_threshold <= cfg_data[15:0];
        vas_pkg::REG_END_THR:   end_threshold <= cfg_data[15:0];
        vas_pkg::REG_START_FR:  start_frames <= cfg_data[7:0];
        vas_pkg::REG_SIL_LIM:   silence_frames_limit <= cfg_data[9:0];
        vas_pkg::REG_MIN_UTT:   min_utterance <= cfg_data;
        vas_pkg::REG_MAX_UTT:   max_utterance <= cfg_data;
        default: ;
      endcase
    end
  end

  vas_front u_front (
    .clk, .rst, .in_valid, .in_stall, .sample, .frame_end,
    .q_valid, .q_stall, .q_data
  );

  vas_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_data,
    .start_threshold, .end_threshold, .start_frames, .silence_frames_limit,
    .min_utterance, .max_utterance,
    .out_valid, .out_stall, .rms_value, .wave_level, .meter_level, .speech_on,
    .frame_taken, .utterance_event, .hit_length_cap, .utterance_length
  );

endmodule

### tb/voice_activity_segmenter_core_tb.sv
module voice_activity_segmenter_core_tb;

  typedef struct packed {
    logic [15:0] rms;
    logic [7:0]  wave;
    logic [7:0]  meter;
    logic        speech;
    logic        taken;
    logic [1:0]  event_code;
    logic        cap;
    logic [19:0] length;
  } frame_result_t;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               last;
    logic               typed;
    frame_result_t      res;
  } stim_row_t;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE = 300;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] sample;
  logic               frame_end;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        rms_value;
  logic [7:0]         wave_level;
  logic [7:0]         meter_level;
  logic               speech_on;
  logic               frame_taken;
  logic [1:0]         utterance_event;
  logic               hit_length_cap;
  logic [19:0]        utterance_length;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [19:0]        cfg_data;

  voice_activity_segmenter_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .frame_end(frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .rms_value(rms_value), .wave_level(wave_level), .meter_level(meter_level),
    .speech_on(speech_on), .frame_taken(frame_taken), .utterance_event(utterance_event),
    .hit_length_cap(hit_length_cap), .utterance_length(utterance_length),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model registers
  int unsigned thr_start, thr_end, frames_to_start, silence_limit, utt_min, utt_max;
  // model frame and segment state
  longint unsigned sq_acc;
  int unsigned peak_acc, frame_len, voiced_cnt, silent_cnt, utt_len, rms_hold;
  bit in_speech;

  frame_result_t pending_frames[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned floor_root(longint unsigned v);
    longint unsigned b, r;
    b = 64'd1 << 62;
    r = 0;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return int'(r);
  endfunction

  function automatic int unsigned map_level(int unsigned v, int unsigned lo, int unsigned hi);
    if (v <= lo) return 0;
    if (v >= hi) return 255;
    return ((v - lo) * 255) / (hi - lo);
  endfunction

  function automatic void close_utterance();
    utt_len = 0;
    in_speech = 0;
    silent_cnt = 0;
    voiced_cnt = 0;
    rms_hold = 0;
  endfunction

  // returns 1 when the sample closes a frame
  function automatic bit segment_sample(input logic signed [15:0] s, input logic last,
                                        output frame_result_t r);
    int unsigned mag, n, rms, pk, plev, rlev, lo, hi;
    bit voiced;
    mag = (s < 0) ? int'(-int'(s)) : int'(s);
    r = '0;
    sq_acc += longint'(mag) * longint'(mag);
    if (mag > peak_acc) peak_acc = mag;
    frame_len++;
    if (!last && frame_len < vas_pkg::FRAME_MAX) return 0;
    n = frame_len;
    rms = floor_root(sq_acc / n);
    pk = (peak_acc > 2200) ? 2200 : peak_acc;
    plev = (pk * 255) / 2200;
    rlev = map_level(rms, 40, 2200);
    sq_acc = 0;
    peak_acc = 0;
    frame_len = 0;
    rms_hold = rms;
    voiced = rms >= (in_speech ? thr_end : thr_start);
    r.event_code = vas_pkg::EV_NONE;
    if (!in_speech) begin
      if (voiced) begin
        if (voiced_cnt < 255) voiced_cnt++;
        if (voiced_cnt >= frames_to_start) begin
          in_speech = 1;
          silent_cnt = 0;
          utt_len = 0;
        end
      end else begin
        voiced_cnt = 0;
      end
    end else if (utt_len + n > utt_max) begin
      r.cap = 1;
      r.length = utt_len[19:0];
      r.event_code = (utt_len < utt_min) ? vas_pkg::EV_DISCARD : vas_pkg::EV_ACCEPT;
      close_utterance();
    end else begin
      r.taken = 1;
      utt_len += n;
      if (voiced) begin
        silent_cnt = 0;
      end else begin
        if (silent_cnt < 1023) silent_cnt++;
        if (silent_cnt >= silence_limit) begin
          r.length = utt_len[19:0];
          r.event_code = (utt_len < utt_min) ? vas_pkg::EV_DISCARD : vas_pkg::EV_ACCEPT;
          close_utterance();
        end
      end
    end
    if (rms_hold == 0) begin
      r.meter = 0;
    end else begin
      lo = in_speech ? thr_end : 80;
      hi = in_speech ? 9000 : 2200;
      r.meter = 8'(map_level(rms_hold, lo, hi));
    end
    r.rms = rms[15:0];
    r.wave = 8'((plev > rlev) ? plev : rlev);
    r.speech = in_speech;
    return 1;
  endfunction

  // writes all six registers on back-to-back edges
  task automatic load_config(input int unsigned v[6]);
    cfg_we <= 1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= i[2:0];
      cfg_data <= v[i][19:0];
      @(posedge clk);
    end
    cfg_we <= 0;
    thr_start = v[vas_pkg::REG_START_THR] & 16'hFFFF;
    thr_end = v[vas_pkg::REG_END_THR] & 16'hFFFF;
    frames_to_start = v[vas_pkg::REG_START_FR] & 8'hFF;
    silence_limit = v[vas_pkg::REG_SIL_LIM] & 10'h3FF;
    utt_min = v[vas_pkg::REG_MIN_UTT] & 20'hFFFFF;
    utt_max = v[vas_pkg::REG_MAX_UTT] & 20'hFFFFF;
  endtask

  task automatic send_sample(input logic signed [15:0] s, input logic last, input bit typed,
                             input frame_result_t typed_res);
    bit st;
    frame_result_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sample <= s;
    frame_end <= last;
    forever begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
      if (!st) break;
    end
    if (segment_sample(s, last, r)) pending_frames.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result rms=%0d", rms_value);
        errors++;
      end else begin
        e = pending_frames.pop_front();
        if (rms_value !== e.rms) begin
          $error("rms_value expected %0d got %0d", e.rms, rms_value); errors++;
        end
        if (wave_level !== e.wave) begin
          $error("wave_level expected %0d got %0d", e.wave, wave_level); errors++;
        end
        if (meter_level !== e.meter) begin
          $error("meter_level expected %0d got %0d", e.meter, meter_level); errors++;
        end
        if (speech_on !== e.speech) begin
          $error("speech_on expected %0d got %0d", e.speech, speech_on); errors++;
        end
        if (frame_taken !== e.taken) begin
          $error("frame_taken expected %0d got %0d", e.taken, frame_taken); errors++;
        end
        if (utterance_event !== e.event_code) begin
          $error("utterance_event expected %0d got %0d", e.event_code, utterance_event);
          errors++;
        end
        if (hit_length_cap !== e.cap) begin
          $error("hit_length_cap expected %0d got %0d", e.cap, hit_length_cap); errors++;
        end
        if (utterance_length !== e.length) begin
          $error("utterance_length expected %0d got %0d", e.length, utterance_length);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows[20];
    int unsigned cfg_set[6];
    int cnt, flen, amp, v, loud_left, quiet_left;
    bit loud;
    logic signed [15:0] s;

    rst = 1;
    in_valid = 0;
    sample = 0;
    frame_end = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    thr_start = 400; thr_end = 200; frames_to_start = 3; silence_limit = 25;
    utt_min = 4800; utt_max = 160000;
    sq_acc = 0; peak_acc = 0; frame_len = 0; voiced_cnt = 0; silent_cnt = 0;
    utt_len = 0; rms_hold = 0; in_speech = 0;

    rows = '{
      '{16'sd0,      1'b1, 1'b1, '{16'd0,     8'd0,   8'd0,   1'b0, 1'b0,
                                   vas_pkg::EV_NONE, 1'b0, 20'd0}},
      '{16'sh8000,   1'b1, 1'b1, '{16'd32768, 8'd255, 8'd255, 1'b0, 1'b0,
                                   vas_pkg::EV_NONE, 1'b0, 20'd0}},
      '{16'sd32767,  1'b1, 1'b1, '{16'd32767, 8'd255, 8'd255, 1'b0, 1'b0,
                                   vas_pkg::EV_NONE, 1'b0, 20'd0}},
      // third voiced frame starts speech and is not taken
      '{16'sd32767,  1'b1, 1'b1, '{16'd32767, 8'd255, 8'd255, 1'b1, 1'b0,
                                   vas_pkg::EV_NONE, 1'b0, 20'd0}},
      '{16'sd40,     1'b0, 1'b0, '0},
      '{-16'sd40,    1'b0, 1'b0, '0},
      '{16'sd40,     1'b1, 1'b0, '0},
      '{16'sd1,      1'b0, 1'b0, '0},
      '{-16'sd1,     1'b1, 1'b0, '0},
      '{16'sd2200,   1'b1, 1'b0, '0},
      '{-16'sd2201,  1'b1, 1'b0, '0},
      '{16'sd9000,   1'b0, 1'b0, '0},
      '{-16'sd9001,  1'b1, 1'b0, '0},
      '{16'sd199,    1'b1, 1'b0, '0},
      '{16'sd200,    1'b1, 1'b0, '0},
      '{16'sd79,     1'b0, 1'b0, '0},
      '{16'sd81,     1'b1, 1'b0, '0},
      '{16'sh5555,   1'b0, 1'b0, '0},
      '{-16'sh2AAB,  1'b0, 1'b0, '0},
      '{16'sd0,      1'b1, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    snd_idle = 32;
    rcv_idle = 53;
    for (int i = 0; i < 20; i++) send_sample(rows[i].smp, rows[i].last, rows[i].typed, rows[i].res);
    drain();

    loud_left = 0;
    quiet_left = 0;
    for (int p = 0; p < 6; p++) begin
      unique case (p)
        0: cfg_set = '{400, 200, 3, 4, 300, 3000};
        1: cfg_set = '{0, 0, 0, 0, 0, 1};
        2: cfg_set = '{65535, 65535, 255, 1023, 1048575, 1048575};
        // floor at or above the meter ceiling
        4: cfg_set = '{500, 9500, 1, 2, 100, 4000};
        default: begin
          cfg_set[vas_pkg::REG_START_THR] = $urandom_range(200, 3000);
          cfg_set[vas_pkg::REG_END_THR] = $urandom_range(50, cfg_set[vas_pkg::REG_START_THR]);
          cfg_set[vas_pkg::REG_START_FR] = $urandom_range(0, 5);
          cfg_set[vas_pkg::REG_SIL_LIM] = $urandom_range(0, 8);
          cfg_set[vas_pkg::REG_MIN_UTT] = $urandom_range(0, 2000);
          cfg_set[vas_pkg::REG_MAX_UTT] = $urandom_range(50, 5000);
        end
      endcase
      if (p < 2) begin
        snd_idle = 32; rcv_idle = 53;
      end else if (p < 4) begin
        snd_idle = 53; rcv_idle = 32;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      load_config(cfg_set);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if (loud_left == 0 && quiet_left == 0) begin
          loud_left = $urandom_range(0, 6);
          quiet_left = $urandom_range(0, 10);
        end
        if (loud_left > 0) begin
          loud = 1;
          loud_left--;
        end else begin
          loud = 0;
          if (quiet_left > 0) quiet_left--;
        end
        if ($urandom_range(9) == 0) loud = 1'($urandom_range(1));
        // one frame runs past the frame limit
        flen = (p == 5 && cnt == 0) ? 1100 : $urandom_range(1, 48);
        amp = loud ? $urandom_range(300, 32767) : $urandom_range(0, 150);
        for (int i = 0; i < flen; i++) begin
          if ($urandom_range(49) == 0) begin
            s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          end else begin
            v = amp - $urandom_range(0, amp / 4);
            if ($urandom_range(1)) v = -v;
            s = v[15:0];
          end
          send_sample(s, i == flen - 1, 0, '0);
          cnt++;
          if (p == 3 && cnt == 50) hold_req = 1;
        end
      end
      drain();
    end

    if (errors == 0 && pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (pending_frames.size() != 0) $error("%0d results never arrived", pending_frames.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
